// ===== rtl/spp_pkg.sv =====
// Shared types and constants of the spline path player.
`default_nettype none

package spp_pkg;

	localparam int unsigned COORD_W   = 32;
	localparam int unsigned NUM_COORD = 6;
	localparam int unsigned T_W       = 21;
	localparam int unsigned W_W       = 32;
	localparam int unsigned PROD_W    = 64;
	localparam int unsigned ACC_W     = 66;
	localparam int unsigned STEP_W    = 17;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] REG_ACTIVE_PATH   = 2'd0;
	localparam logic [1:0] REG_LENGTH_LEFT   = 2'd1;
	localparam logic [1:0] REG_LENGTH_CENTER = 2'd2;
	localparam logic [1:0] REG_LENGTH_RIGHT  = 2'd3;

	localparam logic [STEP_W-1:0] STEP_FULL = 17'h10000;

	localparam logic signed [T_W-1:0] T_MAX = 21'sh80000;
	localparam logic signed [T_W-1:0] T_MIN = -21'sh80000;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = 66'sd32768;
	localparam logic signed [ACC_W-1:0] SAT_HI     = 66'sd2147483647;
	localparam logic signed [ACC_W-1:0] SAT_LO     = -66'sd2147483648;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [W_W-1:0] weight_t;
	typedef weight_t [3:0] weight_vec_t;

	typedef struct packed {
		logic        func;
		logic [1:0]  key_path;
		logic [5:0]  key_slot;
		coord_t      key_x;
		coord_t      key_y;
		coord_t      key_z;
		coord_t      aim_x;
		coord_t      aim_y;
		coord_t      aim_z;
		logic [31:0] key_time;
		logic [31:0] time_delta;
	} in_item_t;

	typedef struct packed {
		logic       playing;
		logic [5:0] current_key;
		coord_t     pos_x;
		coord_t     pos_y;
		coord_t     pos_z;
		coord_t     look_x;
		coord_t     look_y;
		coord_t     look_z;
	} out_item_t;

	// Lane 0..2 are the position, lane 3..5 the look-at point.
	typedef struct packed {
		coord_t [NUM_COORD-1:0] coord;
		logic [31:0]            duration;
	} key_word_t;

endpackage

`default_nettype wire

// ===== rtl/spp_key_mem.sv =====
// Key store: one write port and one registered read port.
`default_nettype none

module spp_key_mem #(
	parameter int unsigned DEPTH = 192
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire spp_pkg::key_word_t        wdata,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output spp_pkg::key_word_t             rdata
);
	import spp_pkg::*;

	key_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/spp_step_div.sv =====
// Radix-2 restoring divider giving the capped progress step.
`default_nettype none

module spp_step_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [31:0]                 dividend,
	input  wire logic [31:0]                 divisor,
	output logic                             done,
	output logic [spp_pkg::STEP_W-1:0]       quotient
);
	import spp_pkg::*;

	logic        busy_q;
	logic        sat_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [15:0] quo_q;
	logic [32:0] shifted;
	logic        fits;

	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sat_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvs_q <= divisor;
				quo_q <= '0;
				rem_q <= dividend;
				// A delta of at least one duration saturates the step at one key.
				if (dividend >= divisor) begin
					sat_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					sat_q  <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= 5'd16;
				end
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= 32'(shifted - {1'b0, dvs_q});
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= shifted[31:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = sat_q ? STEP_FULL : {1'b0, quo_q};

endmodule

`default_nettype wire

// ===== rtl/spp_weight_gen.sv =====
// Catmull-Rom basis weights of a clamped signed Q5.16 parameter, step by step.
`default_nettype none

module spp_weight_gen (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic signed [spp_pkg::T_W-1:0] t,
	output logic                                done,
	output spp_pkg::weight_vec_t                w
);
	import spp_pkg::*;

	typedef enum logic [2:0] {W_IDLE, W_SQ, W_SPLIT, W_CUBE, W_SUM, W_RND} wstate_t;

	wstate_t                  state_q;
	logic                     done_q;
	logic signed [T_W-1:0]    t_q;
	logic [38:0]              t2_q;
	logic signed [40:0]       ph_q;
	logic signed [41:0]       pl_q;
	logic signed [63:0]       t3_q;
	logic signed [63:0]       w2_q [4];
	weight_vec_t              w_q;

	logic signed [2*T_W-1:0]  sq_c;
	logic signed [40:0]       ph_c;
	logic signed [41:0]       pl_c;
	logic signed [63:0]       t2e;
	logic signed [63:0]       te;
	logic signed [63:0]       t3x3;

	// The square is split so that the cube needs only narrow products.
	assign sq_c = t_q * t_q;
	assign ph_c = $signed({1'b0, t2_q[38:20]}) * t_q;
	assign pl_c = $signed({1'b0, t2_q[19:0]}) * t_q;
	assign t2e  = $signed(64'(t2_q));
	assign te   = 64'(t_q);
	assign t3x3 = t3_q + (t3_q <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done_q  <= 1'b0;
			t_q     <= '0;
			t2_q    <= '0;
			ph_q    <= '0;
			pl_q    <= '0;
			t3_q    <= '0;
			w_q     <= '0;
			for (int j = 0; j < 4; j++) begin
				w2_q[j] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				W_IDLE: begin
					if (start) begin
						t_q     <= t;
						state_q <= W_SQ;
					end
				end
				W_SQ: begin
					t2_q    <= 39'(sq_c);
					state_q <= W_SPLIT;
				end
				W_SPLIT: begin
					ph_q    <= ph_c;
					pl_q    <= pl_c;
					state_q <= W_CUBE;
				end
				W_CUBE: begin
					t3_q    <= (64'(ph_q) <<< 20) + 64'(pl_q);
					state_q <= W_SUM;
				end
				W_SUM: begin
					// Twice each weight, with 48 fractional bits.
					w2_q[0] <= -t3_q + (t2e <<< 17) - (te <<< 32);
					w2_q[1] <= t3x3 - ((t2e <<< 16) + (t2e <<< 18))
						+ 64'sh2_0000_0000_0000;
					w2_q[2] <= -t3x3 + (t2e <<< 18) + (te <<< 32);
					w2_q[3] <= t3_q - (t2e <<< 16);
					state_q <= W_RND;
				end
				W_RND: begin
					for (int j = 0; j < 4; j++) begin
						w_q[j] <= W_W'((w2_q[j] + 64'sh1_0000_0000) >>> 33);
					end
					done_q  <= 1'b1;
					state_q <= W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign w    = w_q;

endmodule

`default_nettype wire

// ===== rtl/spline_path_player.sv =====
// Spline path player: key store, tick sequencer and Catmull-Rom blending lanes.
// A load or a tick without motion goes straight to S_FIN for the output register. A tick
// with motion runs the skip check, the step divider, the weight unit and the neighbour key
// reads, with a further skip read per zero-duration key skipped; the divider's loop is
// bypassed when the step saturates at one key. One item at a time: a stalled output holds
// the next beat back. Reset clears progress, registers and control; key store is undefined.
`default_nettype none

module spline_path_player #(
	parameter int unsigned MAX_KEYS  = 64,
	parameter int unsigned NUM_PATHS = 3
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire spp_pkg::in_item_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output spp_pkg::out_item_t  out_item,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_idx,
	input  wire logic [6:0]     cfg_data
);
	import spp_pkg::*;

	localparam int unsigned DEPTH = NUM_PATHS * MAX_KEYS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned KIDX  = $clog2(MAX_KEYS);
	localparam int unsigned KCW   = $clog2(MAX_KEYS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SKIP_RD, S_SKIP_CHK, S_DIV, S_TCALC, S_WGT,
		S_KEY_RD, S_KEY_MUL, S_KEY_ACC, S_ROUND, S_FIN
	} state_t;

	// Configuration registers.
	logic [1:0] active_path_q;
	logic [6:0] length_left_q;
	logic [6:0] length_center_q;
	logic [6:0] length_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_path_q   <= '0;
			length_left_q   <= '0;
			length_center_q <= '0;
			length_right_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACTIVE_PATH:   active_path_q   <= cfg_data[1:0];
				REG_LENGTH_LEFT:   length_left_q   <= cfg_data;
				REG_LENGTH_CENTER: length_center_q <= cfg_data;
				REG_LENGTH_RIGHT:  length_right_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t                   state_q;
	logic [31:0]              prog_q;
	logic [KIDX-1:0]          frame_q;
	logic [KCW-1:0]           size_q;
	logic [AW-1:0]            base_q;
	logic [31:0]              td_q;
	logic [1:0]               j_q;
	logic signed [PROD_W-1:0] prod_s1 [NUM_COORD];
	logic signed [ACC_W-1:0]  acc_q [NUM_COORD];
	out_item_t                res_q;
	out_item_t                out_q;
	logic                     out_valid_q;

	logic       in_fire;
	logic       load_ok;
	logic       mem_we;
	logic [AW-1:0] mem_waddr;
	key_word_t  mem_wdata;
	logic [AW-1:0] mem_raddr;
	key_word_t  mem_rdata;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// A load beat writes the key straight into the store when path and slot exist.
	assign load_ok   = (32'(in_item.key_path) < NUM_PATHS) && (32'(in_item.key_slot) < MAX_KEYS);
	assign mem_we    = in_fire && (in_item.func == FUNC_LOAD) && load_ok;
	assign mem_waddr = AW'(AW'(in_item.key_path) * AW'(MAX_KEYS)) + AW'(in_item.key_slot);
	assign mem_wdata.coord[0] = in_item.key_x;
	assign mem_wdata.coord[1] = in_item.key_y;
	assign mem_wdata.coord[2] = in_item.key_z;
	assign mem_wdata.coord[3] = in_item.aim_x;
	assign mem_wdata.coord[4] = in_item.aim_y;
	assign mem_wdata.coord[5] = in_item.aim_z;
	assign mem_wdata.duration = in_item.key_time;

	// Tick checks, made on the beat itself from the registers and the current progress.
	logic [6:0]     len_sel;
	logic           path_ok;
	logic [KCW-1:0] size_c;
	logic [16:0]    frame_c;
	logic           path_end_c;

	always_comb begin
		case (active_path_q)
			2'd0:    len_sel = length_left_q;
			2'd1:    len_sel = length_center_q;
			2'd2:    len_sel = length_right_q;
			default: len_sel = '0;
		endcase
	end

	assign path_ok    = (32'(active_path_q) < NUM_PATHS) && (active_path_q != 2'd3);
	assign size_c     = (32'(len_sel) > MAX_KEYS) ? KCW'(MAX_KEYS) : KCW'(len_sel);
	assign frame_c    = {1'b0, prog_q[31:16]} + 17'd1;
	assign path_end_c = (18'(frame_c) + 18'd1) >= 18'(size_c);

	// Skip loop: the next key index and whether it runs past the last segment.
	logic [KCW-1:0] frame_next;
	logic           skip_end;

	assign frame_next = KCW'(frame_q) + KCW'(1);
	assign skip_end   = frame_next >= (size_q - KCW'(1));

	// Neighbour key index, clamped below at key 1 and above at the last key of the path.
	logic [KCW:0]  k_raw;
	logic [KCW:0]  k_hi;
	logic [KIDX-1:0] k_sel;

	assign k_raw = (KCW+1)'(frame_q) + (KCW+1)'(j_q) - (KCW+1)'(1);
	assign k_hi  = (KCW+1)'(size_q) - (KCW+1)'(1);

	always_comb begin
		if (k_raw > k_hi) begin
			k_sel = KIDX'(k_hi);
		end else if (k_raw < (KCW+1)'(1)) begin
			k_sel = KIDX'(1);
		end else begin
			k_sel = KIDX'(k_raw);
		end
	end

	always_comb begin
		case (state_q)
			S_KEY_RD: mem_raddr = base_q + AW'(k_sel);
			default:  mem_raddr = base_q + AW'(frame_q);
		endcase
	end

	spp_key_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Step of the progress: the delta over the segment duration, capped at one key.
	logic              div_start;
	logic              div_done;
	logic [STEP_W-1:0] step;
	logic [32:0]       prog_sum;

	assign div_start = (state_q == S_SKIP_CHK) && (mem_rdata.duration != '0);
	assign prog_sum  = {1'b0, prog_q} + 33'(step);

	spp_step_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (td_q),
		.divisor  (mem_rdata.duration),
		.done     (div_done),
		.quotient (step)
	);

	// Segment parameter: progress less the start of the segment, clamped to eight keys.
	// The progress has settled by the time the sequencer sits in S_TCALC, so the weight
	// unit takes the clamped value directly on its start.
	logic signed [33:0] t_raw;
	logic signed [T_W-1:0] t_c;

	assign t_raw = $signed({2'b00, prog_q}) - $signed({18'(frame_q) - 18'd1, 16'h0000});

	always_comb begin
		if (t_raw > 34'(T_MAX)) begin
			t_c = T_MAX;
		end else if (t_raw < 34'(T_MIN)) begin
			t_c = T_MIN;
		end else begin
			t_c = T_W'(t_raw);
		end
	end

	logic        wgt_done;
	weight_vec_t wgt;
	weight_t     w_sel;

	spp_weight_gen u_wgt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_TCALC),
		.t      (t_c),
		.done   (wgt_done),
		.w      (wgt)
	);

	assign w_sel = wgt[j_q];

	// Round to nearest, ties upward, and saturate each lane to 32 bits.
	logic signed [ACC_W-1:0] rnd [NUM_COORD];
	coord_t                  lane_out [NUM_COORD];

	always_comb begin
		for (int c = 0; c < NUM_COORD; c++) begin
			rnd[c] = (acc_q[c] + ROUND_HALF) >>> 16;
			if (rnd[c] > SAT_HI) begin
				lane_out[c] = 32'sh7FFF_FFFF;
			end else if (rnd[c] < SAT_LO) begin
				lane_out[c] = 32'sh8000_0000;
			end else begin
				lane_out[c] = rnd[c][31:0];
			end
		end
	end

	// Sequencer: holds state, the progress, the lane accumulators and the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prog_q      <= '0;
			frame_q     <= '0;
			size_q      <= '0;
			base_q      <= '0;
			td_q        <= '0;
			j_q         <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_COORD; c++) begin
				prod_s1[c] <= '0;
				acc_q[c]   <= '0;
			end
		end else begin
			// In S_FIN the hand-over below decides the output valid on its own.
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						res_q   <= '0;
						state_q <= S_FIN;
						// Loads, a missing path, short paths and a tick at the path's end give an empty result.
						if (in_item.func == FUNC_TICK && path_ok && size_c >= KCW'(4)) begin
							if (path_end_c) begin
								prog_q <= '0;
							end else begin
								frame_q <= KIDX'(frame_c);
								size_q  <= size_c;
								base_q  <= AW'(AW'(active_path_q) * AW'(MAX_KEYS));
								td_q    <= in_item.time_delta;
								state_q <= S_SKIP_RD;
							end
						end
					end
				end
				S_SKIP_RD: begin
					state_q <= S_SKIP_CHK;
				end
				S_SKIP_CHK: begin
					if (mem_rdata.duration != '0) begin
						state_q <= S_DIV;
					end else if (skip_end) begin
						// Every remaining segment has zero duration: the path ends.
						prog_q  <= '0;
						state_q <= S_FIN;
					end else begin
						frame_q <= KIDX'(frame_next);
						state_q <= S_SKIP_RD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						prog_q  <= prog_sum[32] ? '1 : prog_sum[31:0];
						state_q <= S_TCALC;
					end
				end
				S_TCALC: begin
					state_q <= S_WGT;
				end
				S_WGT: begin
					if (wgt_done) begin
						j_q     <= '0;
						state_q <= S_KEY_RD;
						for (int c = 0; c < NUM_COORD; c++) begin
							acc_q[c] <= '0;
						end
					end
				end
				S_KEY_RD: begin
					state_q <= S_KEY_MUL;
				end
				S_KEY_MUL: begin
					for (int c = 0; c < NUM_COORD; c++) begin
						prod_s1[c] <= $signed(w_sel) * $signed(mem_rdata.coord[c]);
					end
					state_q <= S_KEY_ACC;
				end
				S_KEY_ACC: begin
					for (int c = 0; c < NUM_COORD; c++) begin
						acc_q[c] <= acc_q[c] + ACC_W'(prod_s1[c]);
					end
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) begin
						state_q <= S_ROUND;
					end else begin
						state_q <= S_KEY_RD;
					end
				end
				S_ROUND: begin
					res_q.playing     <= 1'b1;
					res_q.current_key <= 6'(frame_q);
					res_q.pos_x       <= lane_out[0];
					res_q.pos_y       <= lane_out[1];
					res_q.pos_z       <= lane_out[2];
					res_q.look_x      <= lane_out[3];
					res_q.look_y      <= lane_out[4];
					res_q.look_z      <= lane_out[5];
					state_q           <= S_FIN;
				end
				S_FIN: begin
					// The result moves out once the output register is free.
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef NO_ASSERTIONS
	// The progress only moves at the end of a tick's step or when a path ends.
	a_prog_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(prog_q) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_SKIP_CHK
			|| $past(state_q) == S_DIV))
		else $error("progress changed outside a tick");

	// The divider only reports while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished out of sequence");

	// The weight unit only reports while the sequencer waits for it.
	a_wgt_done: assert property (@(posedge clk) disable iff (!arst_n)
		wgt_done |-> state_q == S_WGT)
		else $error("weights finished out of sequence");

	// A beat without motion carries no coordinates.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.playing) |-> (out_q.current_key == '0
			&& out_q.pos_x == '0 && out_q.pos_y == '0 && out_q.pos_z == '0
			&& out_q.look_x == '0 && out_q.look_y == '0 && out_q.look_z == '0))
		else $error("empty result carries data");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the spline path player: key loads, ticks and the blended points.
`timescale 1ns / 100ps

module tb_top;
	import spp_pkg::*;

	localparam int unsigned KEYS   = 64;
	localparam int unsigned PATHS  = 3;
	localparam int unsigned DEPTH  = KEYS * PATHS;
	localparam int unsigned CYCLE_LIMIT = 3000000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [6:0] cfg_data;

	spline_path_player dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	// The clock toggles every half period of 4 ns.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Our own copy of the block's state: the key store, the progress and the registers.
	coord_t      shadow_coord [6][DEPTH];
	logic [31:0] shadow_dur [DEPTH];
	logic [31:0] shadow_progress;
	logic [1:0]  shadow_active;
	logic [6:0]  shadow_len [3];

	in_item_t  beats_to_send [$];
	out_item_t points_due [$];
	int unsigned fail_count;
	int unsigned cycle_count;
	bit          quiet;
	bit          in_fire;
	int unsigned src_gap;
	int unsigned sink_gap;

	// Appends one beat to the tail of the pending queue.
	function automatic void queue_beat(input in_item_t it);
		beats_to_send.insert(beats_to_send.size(), it);
	endfunction

	// Weighted sum of four keys in one lane, rounded half up and saturated to 32 bits.
	function automatic coord_t blend_lane(input longint w [4], input int lane,
			input int unsigned idx [4]);
		longint acc;
		longint r;
		acc = 0;
		for (int j = 0; j < 4; j++)
			acc += w[j] * longint'(shadow_coord[lane][idx[j]]);
		r = (acc + 64'sd32768) >>> 16;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return coord_t'(r[31:0]);
	endfunction

	// Works out the point that one accepted beat produces and updates our state copy.
	function automatic out_item_t advance_player(input in_item_t it);
		out_item_t   res;
		int unsigned base, size, frame, a;
		longint unsigned q;
		logic [31:0] step;
		longint      t, t2, t3;
		longint      w2 [4];
		longint      w [4];
		int unsigned idx [4];
		int unsigned k;
		res = '0;
		if (it.func == FUNC_LOAD) begin
			if (it.key_path < PATHS) begin
				a = it.key_path * KEYS + it.key_slot;
				shadow_coord[0][a] = it.key_x;
				shadow_coord[1][a] = it.key_y;
				shadow_coord[2][a] = it.key_z;
				shadow_coord[3][a] = it.aim_x;
				shadow_coord[4][a] = it.aim_y;
				shadow_coord[5][a] = it.aim_z;
				shadow_dur[a] = it.key_time;
			end
			return res;
		end
		if (shadow_active >= PATHS)
			return res;
		size = shadow_len[shadow_active];
		if (size > KEYS)
			size = KEYS;
		if (size < 4)
			return res;
		base = shadow_active * KEYS;
		frame = (shadow_progress >> 16) + 1;
		if (frame + 1 >= size) begin
			shadow_progress = '0;
			return res;
		end
		// Zero-duration keys are skipped; a skip that runs out of keys ends the path.
		while (frame < size - 1 && shadow_dur[base + frame] == 0)
			frame++;
		if (frame >= size - 1) begin
			shadow_progress = '0;
			return res;
		end
		q = {16'd0, it.time_delta, 16'd0} / {32'd0, shadow_dur[base + frame]};
		step = (q > 64'h10000) ? 32'h10000 : q[31:0];
		shadow_progress = (shadow_progress > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF
			: shadow_progress + step;
		t = longint'({32'd0, shadow_progress}) - (longint'(frame - 1) <<< 16);
		if (t > (64'sd8 <<< 16))
			t = 64'sd8 <<< 16;
		if (t < -(64'sd8 <<< 16))
			t = -(64'sd8 <<< 16);
		t2 = t * t;
		t3 = t2 * t;
		w2[0] = -t3 + 2 * t2 * 65536 - t * (64'sd1 <<< 32);
		w2[1] = 3 * t3 - 5 * t2 * 65536 + (64'sd2 <<< 48);
		w2[2] = -3 * t3 + 4 * t2 * 65536 + t * (64'sd1 <<< 32);
		w2[3] = t3 - t2 * 65536;
		for (int j = 0; j < 4; j++) begin
			k = frame + j;
			k = (k == 0) ? 0 : k - 1;
			if (k > size - 1)
				k = size - 1;
			if (k < 1)
				k = 1;
			idx[j] = base + k;
			w[j] = (w2[j] + (64'sd1 <<< 32)) >>> 33;
		end
		res.playing     = 1'b1;
		res.current_key = frame[5:0];
		res.pos_x  = blend_lane(w, 0, idx);
		res.pos_y  = blend_lane(w, 1, idx);
		res.pos_z  = blend_lane(w, 2, idx);
		res.look_x = blend_lane(w, 3, idx);
		res.look_y = blend_lane(w, 4, idx);
		res.look_z = blend_lane(w, 5, idx);
		return res;
	endfunction

	// Sampling at the rising edge: accepted input beats feed the predictor, accepted
	// output beats are compared field by field with the oldest predicted point.
	always @(posedge clk) begin
		out_item_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			in_fire = arst_n && in_valid && in_ready;
			if (in_fire)
				points_due.insert(points_due.size(), advance_player(in_item));
			if (arst_n && out_valid && out_ready) begin
				if (points_due.size() == 0) begin
					$error("unexpected output beat");
					fail_count++;
				end else begin
					want = points_due.pop_front();
					if (out_item.playing !== want.playing) begin
						$error("playing: expected %0d, got %0d", want.playing, out_item.playing);
						fail_count++;
					end
					if (out_item.current_key !== want.current_key) begin
						$error("current_key: expected %0d, got %0d", want.current_key,
							out_item.current_key);
						fail_count++;
					end
					if (out_item.pos_x !== want.pos_x) begin
						$error("pos_x: expected %h, got %h", want.pos_x, out_item.pos_x);
						fail_count++;
					end
					if (out_item.pos_y !== want.pos_y) begin
						$error("pos_y: expected %h, got %h", want.pos_y, out_item.pos_y);
						fail_count++;
					end
					if (out_item.pos_z !== want.pos_z) begin
						$error("pos_z: expected %h, got %h", want.pos_z, out_item.pos_z);
						fail_count++;
					end
					if (out_item.look_x !== want.look_x) begin
						$error("look_x: expected %h, got %h", want.look_x, out_item.look_x);
						fail_count++;
					end
					if (out_item.look_y !== want.look_y) begin
						$error("look_y: expected %h, got %h", want.look_y, out_item.look_y);
						fail_count++;
					end
					if (out_item.look_z !== want.look_z) begin
						$error("look_z: expected %h, got %h", want.look_z, out_item.look_z);
						fail_count++;
					end
				end
			end
		end
	end

	// Driver: at each falling edge the current beat is held until it has been taken,
	// then either an idle burst starts or the next pending beat is presented. Each
	// signal is assigned once per edge so that valid never drops between back-to-back beats.
	always @(negedge clk) begin
		logic     nv;
		in_item_t ni;
		nv = in_valid;
		ni = in_item;
		if (arst_n && !(in_valid && !in_fire)) begin
			nv = 1'b0;
			if (src_gap > 0)
				src_gap--;
			else if (beats_to_send.size() > 0) begin
				if (!quiet && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(0, 10);
				else begin
					ni = beats_to_send.pop_front();
					nv = 1'b1;
				end
			end
		end
		in_valid <= nv;
		in_item  <= ni;
	end

	// Sink: output ready drops in random bursts, except in the quiet tail of the run.
	always @(negedge clk) begin
		logic nr;
		nr = 1'b1;
		if (sink_gap > 0) begin
			sink_gap--;
			nr = 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			sink_gap = $urandom_range(0, 10);
			nr = 1'b0;
		end
		out_ready <= nr;
	end

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3, 4: return coord_t'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(0, 7))
			0, 1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			3: return $urandom;
			default: return $urandom_range(1, 32'h3_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h1_0000);
		endcase
	endfunction

	function automatic in_item_t key_beat(input logic [1:0] p, input logic [5:0] s,
			input logic [31:0] dur);
		in_item_t it;
		it.func       = FUNC_LOAD;
		it.key_path   = p;
		it.key_slot   = s;
		it.key_x      = pick_coord();
		it.key_y      = pick_coord();
		it.key_z      = pick_coord();
		it.aim_x      = pick_coord();
		it.aim_y      = pick_coord();
		it.aim_z      = pick_coord();
		it.key_time   = dur;
		it.time_delta = $urandom;
		return it;
	endfunction

	// A tick carries random values in the fields that it does not use.
	function automatic in_item_t tick_beat(input logic [31:0] delta);
		in_item_t it;
		it            = key_beat(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
			$urandom);
		it.func       = FUNC_TICK;
		it.time_delta = delta;
		return it;
	endfunction

	// Waits until every beat has gone in and every point has come out, then lets
	// the block run on idle before it returns.
	task automatic wait_drained();
		while (beats_to_send.size() > 0 || in_valid || points_due.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_regs(input logic [1:0] act, input logic [6:0] l0,
			input logic [6:0] l1, input logic [6:0] l2);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= REG_ACTIVE_PATH; cfg_data <= {5'd0, act};
		shadow_active = act;
		@(negedge clk);
		cfg_idx <= REG_LENGTH_LEFT; cfg_data <= l0;
		shadow_len[0] = l0;
		@(negedge clk);
		cfg_idx <= REG_LENGTH_CENTER; cfg_data <= l1;
		shadow_len[1] = l1;
		@(negedge clk);
		cfg_idx <= REG_LENGTH_RIGHT; cfg_data <= l2;
		shadow_len[2] = l2;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random phase: mostly ticks on the active path, with reloads of keys mixed in.
	task automatic random_phase(input int unsigned n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7)
				queue_beat(tick_beat(pick_delta()));
			else
				queue_beat(key_beat(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
					pick_duration()));
		end
		wait_drained();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_ACTIVE_PATH;
		cfg_data  = '0;
		fail_count  = 0;
		cycle_count = 0;
		quiet     = 1'b0;
		in_fire   = 1'b0;
		src_gap   = 0;
		sink_gap  = 0;
		shadow_progress = '0;
		shadow_active   = '0;
		for (int i = 0; i < 3; i++)
			shadow_len[i] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every key of every path is written first, so that no tick ever reads an
		// entry of the key store that holds nothing yet.
		for (int p = 0; p < PATHS; p++)
			for (int s = 0; s < KEYS; s++)
				queue_beat(key_beat(2'(p), 6'(s), $urandom_range(1, 32'h2_0000)));
		wait_drained();

		// Directed part: a short path, a load to the missing fourth path and extreme keys.
		write_regs(2'd0, 7'd3, 7'd4, 7'd127);
		queue_beat(tick_beat(32'h1_0000));
		queue_beat(key_beat(2'd3, 6'd63, 32'hFFFF_FFFF));
		begin
			in_item_t hi;
			hi = key_beat(2'd1, 6'd1, 32'h1_0000);
			hi.key_x = 32'sh7FFF_FFFF; hi.key_y = 32'sh7FFF_FFFF; hi.key_z = 32'sh7FFF_FFFF;
			hi.aim_x = 32'sh8000_0000; hi.aim_y = 32'sh8000_0000; hi.aim_z = 32'sh8000_0000;
			queue_beat(hi);
			hi.key_slot = 6'd2;
			queue_beat(hi);
		end
		wait_drained();

		// Four-key path: ticks with zero, small and huge deltas run it to its end.
		write_regs(2'd1, 7'd0, 7'd4, 7'd0);
		queue_beat(tick_beat(32'd0));
		queue_beat(tick_beat(32'h0000_8000));
		queue_beat(tick_beat(32'hFFFF_FFFF));
		queue_beat(tick_beat(32'hFFFF_FFFF));
		queue_beat(tick_beat(32'hFFFF_FFFF));
		queue_beat(tick_beat(32'h0000_4000));
		wait_drained();

		// Skipping: zero durations that run off the end, then one that lands mid-path.
		write_regs(2'd0, 7'd6, 7'd4, 7'd0);
		for (int s = 1; s < 6; s++)
			queue_beat(key_beat(2'd0, 6'(s), 32'd0));
		queue_beat(tick_beat(32'h1_0000));
		queue_beat(key_beat(2'd0, 6'd3, 32'h0_8000));
		queue_beat(tick_beat(32'h0_2000));
		queue_beat(tick_beat(32'h0_2000));
		queue_beat(tick_beat(32'hFFFF_FFFF));
		queue_beat(tick_beat(32'h0_1000));
		wait_drained();

		// A missing active path leaves the progress alone.
		write_regs(2'd3, 7'd64, 7'd64, 7'd64);
		queue_beat(tick_beat(32'h1_0000));
		queue_beat(tick_beat(32'h0_0001));
		wait_drained();

		// Random phases over a spread of register settings, extremes included.
		write_regs(2'd0, 7'd64, 7'd8, 7'd127);
		random_phase(120);
		write_regs(2'd2, 7'd5, 7'd64, 7'd127);
		random_phase(120);
		write_regs(2'd1, 7'd4, 7'd100, 7'd2);
		random_phase(120);
		write_regs(2'd3, 7'd1, 7'd64, 7'd64);
		random_phase(40);
		for (int ph = 0; ph < 3; ph++) begin
			write_regs(2'($urandom_range(0, 2)), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
			random_phase(100);
		end
		write_regs(2'd0, 7'd20, 7'd0, 7'd0);
		quiet = 1'b1;
		random_phase(120);

		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
